FILE: sv/nusf_pkg.sv
// ----------------------------------------------------------------------------
// nusf_pkg: shared types and constants of the NMEA/UBX frame splitter
// Byte codes, phase and tag encodings, and counter widths.
// ----------------------------------------------------------------------------
package nusf_pkg;

  localparam int MAX_LEN = 512;
  localparam int FPOS_W  = $clog2(MAX_LEN + 1);
  localparam int REM_W   = 17;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SYNC1  = 8'hb5;
  localparam logic [7:0] CH_SYNC2  = 8'h62;

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_WANT_G  = 8'b0000_0010,
    PH_TEXT    = 8'b0000_0100,
    PH_SYNC2   = 8'b0000_1000,
    PH_CLASSID = 8'b0001_0000,
    PH_LEN_LO  = 8'b0010_0000,
    PH_LEN_HI  = 8'b0100_0000,
    PH_PAYLOAD = 8'b1000_0000
  } phase_t;

  typedef enum logic [2:0] {
    TAG_IGNORE   = 3'd0,
    TAG_TEXT     = 3'd1,
    TAG_TEXT_END = 3'd2,
    TAG_BIN      = 3'd3,
    TAG_BIN_END  = 3'd4
  } tag_t;

  typedef struct packed {
    tag_t tag;
    logic aborted;
  } result_t;

endpackage

FILE: sv/nusf_tracker.sv
// ----------------------------------------------------------------------------
// nusf_tracker: framing state and byte classifier
// Holds the frame phase and counters, tags the current byte and advances
// the state when step is high.
// ----------------------------------------------------------------------------
module nusf_tracker
  import nusf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    byte_in,
  output result_t       result
);

  localparam logic [FPOS_W-1:0] MAX_POS = FPOS_W'(MAX_LEN);

  phase_t              phase, phase_next, cur;
  logic [FPOS_W-1:0]   frame_pos, frame_pos_next;
  logic [FPOS_W-1:0]   byte_count, byte_count_next, bc_inc;
  logic [REM_W-1:0]    remaining_len, remaining_len_next;

  assign bc_inc = byte_count + FPOS_W'(1);

  always_comb begin
    phase_next         = phase;
    frame_pos_next     = frame_pos;
    byte_count_next    = byte_count;
    remaining_len_next = remaining_len;
    result.tag         = TAG_IGNORE;
    result.aborted     = 1'b0;
    cur                = phase;

    // drop an overlong frame before this beat
    if (frame_pos >= MAX_POS) begin
      if (phase != PH_IDLE) begin
        result.aborted = 1'b1;
      end
      cur        = PH_IDLE;
      phase_next = PH_IDLE;
    end

    unique case (cur)
      PH_IDLE: begin
        frame_pos_next = '0;
        if (byte_in == CH_DOLLAR) begin
          frame_pos_next = FPOS_W'(1);
          phase_next     = PH_WANT_G;
          result.tag     = TAG_TEXT;
        end else if (byte_in == CH_SYNC1) begin
          frame_pos_next = FPOS_W'(1);
          phase_next     = PH_SYNC2;
          result.tag     = TAG_BIN;
        end
      end
      PH_WANT_G: begin
        if (byte_in == CH_G) begin
          frame_pos_next = frame_pos + FPOS_W'(1);
          phase_next     = PH_TEXT;
          result.tag     = TAG_TEXT;
        end
      end
      PH_TEXT: begin
        frame_pos_next = frame_pos + FPOS_W'(1);
        if (byte_in == CH_LF) begin
          phase_next = PH_IDLE;
          result.tag = TAG_TEXT_END;
        end else begin
          result.tag = TAG_TEXT;
        end
      end
      PH_SYNC2: begin
        if (byte_in == CH_SYNC2) begin
          frame_pos_next  = frame_pos + FPOS_W'(1);
          byte_count_next = '0;
          phase_next      = PH_CLASSID;
          result.tag      = TAG_BIN;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_CLASSID: begin
        frame_pos_next  = frame_pos + FPOS_W'(1);
        byte_count_next = bc_inc;
        if (bc_inc == FPOS_W'(2)) begin
          phase_next = PH_LEN_LO;
        end
        result.tag = TAG_BIN;
      end
      PH_LEN_LO: begin
        frame_pos_next     = frame_pos + FPOS_W'(1);
        remaining_len_next = REM_W'(byte_in);
        phase_next         = PH_LEN_HI;
        result.tag         = TAG_BIN;
      end
      PH_LEN_HI: begin
        frame_pos_next     = frame_pos + FPOS_W'(1);
        remaining_len_next = REM_W'({byte_in, remaining_len[7:0]}) + REM_W'(2);
        byte_count_next    = '0;
        phase_next         = PH_PAYLOAD;
        result.tag         = TAG_BIN;
      end
      PH_PAYLOAD: begin
        frame_pos_next  = frame_pos + FPOS_W'(1);
        byte_count_next = bc_inc;
        if (REM_W'(bc_inc) >= remaining_len) begin
          phase_next = PH_IDLE;
          result.tag = TAG_BIN_END;
        end else begin
          result.tag = TAG_BIN;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      frame_pos     <= '0;
      byte_count    <= '0;
      remaining_len <= '0;
    end else if (step) begin
      phase         <= phase_next;
      frame_pos     <= frame_pos_next;
      byte_count    <= byte_count_next;
      remaining_len <= remaining_len_next;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    frame_pos <= MAX_POS)
    else $error("frame position past limit");

  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    step && (result.tag == TAG_TEXT_END || result.tag == TAG_BIN_END) |=> phase == PH_IDLE)
    else $error("frame end did not return to idle");

  a_payload_open: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> REM_W'(byte_count) < remaining_len)
    else $error("payload count reached length without ending frame");

endmodule

FILE: sv/nmea_ubx_frame_splitter.sv
// ----------------------------------------------------------------------------
// nmea_ubx_frame_splitter: tags each byte of a receiver stream
// Takes one byte per beat and returns it with a tag: ignored, text sentence
// byte, sentence line feed, binary frame byte or binary frame end, plus an
// aborted flag when a frame was dropped for reaching MAX_LEN bytes. One beat
// is accepted every cycle while in_stall is low; each byte passes an input
// register and then the result register before it is presented. The framing
// state updates once per byte, so it runs one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module nmea_ubx_frame_splitter
  import nusf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] tag,
  output logic       aborted
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       advance;
  result_t    result;
  result_t    result_q;

  assign advance  = in_valid_q && (!out_valid || !out_stall);
  assign in_stall = in_valid_q && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_q <= rx_byte;
    end
  end

  nusf_tracker u_tracker (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .byte_in (in_byte_q),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= in_byte_q;
      result_q <= result;
    end
  end

  assign tag     = 3'(result_q.tag);
  assign aborted = result_q.aborted;

endmodule
